// ===== rtl/patt_pkg.sv =====
// ----------------------------------------------------------------------------
// patt_pkg
// Shared types and constants of the pending acknowledgement timeout table:
// operation codes, field widths and the request and response payloads.
// ----------------------------------------------------------------------------
package patt_pkg;

	localparam int KIND_BITS        = 2;
	localparam int ID_BITS          = 16;
	localparam int TIME_BITS        = 32;
	localparam int HANDLE_PORT_BITS = 8;
	localparam int SLOT_PORT_BITS   = 3;

	localparam logic [TIME_BITS-1:0] TIME_ALL_ONES = '1;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_ADD    = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_ELAPSE = 2'd2
	} kind_t;

	typedef struct packed {
		logic [KIND_BITS-1:0]        kind;
		logic [ID_BITS-1:0]          pkt_id;
		logic [HANDLE_PORT_BITS-1:0] buffer_handle;
		logic [TIME_BITS-1:0]        timeout_ms;
		logic [TIME_BITS-1:0]        elapsed_ms;
	} req_t;

	typedef struct packed {
		logic                        accepted;
		logic                        released_valid;
		logic [HANDLE_PORT_BITS-1:0] released_handle;
		logic [TIME_BITS-1:0]        min_remaining_ms;
		logic                        expired_found;
		logic [SLOT_PORT_BITS-1:0]   expired_slot;
		logic [ID_BITS-1:0]          expired_pkt_id;
		logic [HANDLE_PORT_BITS-1:0] expired_handle;
	} rsp_t;

endpackage

// ===== rtl/patt_ifs.sv =====
// ----------------------------------------------------------------------------
// patt_ifs
// Valid/ready channels of the timeout table: one for request items, one for
// response items.
// ----------------------------------------------------------------------------
interface patt_req_if;
	logic              valid;
	logic              ready;
	patt_pkg::req_t    data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface patt_rsp_if;
	logic              valid;
	logic              ready;
	patt_pkg::rsp_t    data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/pending_ack_timeout_table_top.sv =====
// ----------------------------------------------------------------------------
// pending_ack_timeout_table_top
// Table of packets waiting for acknowledgement, with per-entry timers.
// ----------------------------------------------------------------------------
// One item is worked at a time. The entries sit in one synchronous memory
// with a single read port: every item scans all slots, one read per cycle,
// then a tail state works on the last read's data and a finish state
// commits an add and registers the response. During the scan an elapse item
// writes each lowered timer back; the same pass collects the least remaining
// time, the lowest expired slot, a duplicate id for an add and the matching
// entry for a delete. Occupancy lives in one flip-flop per slot, cleared at
// reset, so the table is empty right after reset with no clearing pass. A
// finished response waits in an output register; the next request is taken
// while it waits and only its commit stalls until the response is gone.
// Kind three changes nothing and reports accepted low with the table status.
// ----------------------------------------------------------------------------
module pending_ack_timeout_table_top #(
	parameter int TABLE_SLOTS = 8,
	parameter int HANDLE_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	patt_req_if.sink    req,
	patt_rsp_if.source  rsp
);

	localparam int SLOT_BITS = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int HW = (HANDLE_BITS < patt_pkg::HANDLE_PORT_BITS) ?
		HANDLE_BITS : patt_pkg::HANDLE_PORT_BITS;
	localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(TABLE_SLOTS - 1);

	typedef struct packed {
		logic [patt_pkg::ID_BITS-1:0]   id;
		logic [patt_pkg::TIME_BITS-1:0] rem;
		logic [HW-1:0]                  hnd;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_TAIL,
		ST_FINISH
	} state_t;

	state_t state_q;

	// Latched request and the snapshot of table fullness at transfer.
	patt_pkg::req_t op_q;
	logic           full_q;

	// Entry store and occupancy.
	entry_t                  mem [TABLE_SLOTS];
	logic [TABLE_SLOTS-1:0]  valid_q;
	logic                    mem_we;
	logic [SLOT_BITS-1:0]    mem_wa;
	entry_t                  mem_wd;

	// Scan pipeline: read address, then the read data stage.
	logic [SLOT_BITS-1:0]    rd_idx_q;
	entry_t                  rd_s1;
	logic                    vld_s1;
	logic                    occ_s1;
	logic [SLOT_BITS-1:0]    idx_s1;

	// Scan accumulators.
	logic                           dup_q;
	logic                           del_hit_q;
	logic [SLOT_BITS-1:0]           del_slot_q;
	logic [HW-1:0]                  rel_handle_q;
	logic [patt_pkg::TIME_BITS-1:0] min_q;
	logic                           exp_found_q;
	logic [SLOT_BITS-1:0]           exp_slot_q;
	logic [patt_pkg::ID_BITS-1:0]   exp_id_q;
	logic [HW-1:0]                  exp_hnd_q;

	// Response register.
	logic           rsp_valid_q;
	patt_pkg::rsp_t rsp_data_q;

	logic                           req_xfer;
	logic                           finish_go;
	logic                           is_add;
	logic                           is_delete;
	logic                           is_elapse;
	logic                           add_ok;
	logic [SLOT_BITS-1:0]           free_slot;
	logic [patt_pkg::TIME_BITS-1:0] eff_rem_s1;
	logic                           id_hit_s1;
	logic                           counted_s1;
	logic [patt_pkg::TIME_BITS-1:0] min_sel;
	logic                           new_exp;
	logic [SLOT_BITS-1:0]           fin_slot;
	logic [patt_pkg::ID_BITS-1:0]   fin_id;
	logic [HW-1:0]                  fin_hnd;
	logic [SLOT_BITS+2:0]           fin_slot_wide;
	logic [HW+7:0]                  fin_hnd_wide;
	logic [HW+7:0]                  rel_hnd_wide;
	patt_pkg::rsp_t                 rsp_next;

	assign req.ready = (state_q == ST_IDLE);
	assign req_xfer  = req.valid && req.ready;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	assign is_add    = (op_q.kind == patt_pkg::KIND_ADD);
	assign is_delete = (op_q.kind == patt_pkg::KIND_DELETE);
	assign is_elapse = (op_q.kind == patt_pkg::KIND_ELAPSE);

	assign finish_go = (state_q == ST_FINISH) && (!rsp_valid_q || rsp.ready);
	assign add_ok    = is_add && (op_q.pkt_id != '0) && !dup_q && !full_q;

	// Lowest free slot.
	always_comb begin
		free_slot = '0;
		for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_slot = SLOT_BITS'(i);
			end
		end
	end

	// Read data stage: lower the timer for elapse, saturating at zero.
	always_comb begin
		eff_rem_s1 = rd_s1.rem;
		if (is_elapse) begin
			eff_rem_s1 = (rd_s1.rem < op_q.elapsed_ms) ? '0 : rd_s1.rem - op_q.elapsed_ms;
		end
	end

	assign id_hit_s1  = occ_s1 && (rd_s1.id == op_q.pkt_id);
	assign counted_s1 = occ_s1 && !(is_delete && id_hit_s1);

	// Single write port: an add commits at finish, elapse writes back during
	// the scan. The two never fall in the same cycle.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_s1;
		mem_wd = '{id: rd_s1.id, rem: eff_rem_s1, hnd: rd_s1.hnd};
		if (finish_go && add_ok) begin
			mem_we = 1'b1;
			mem_wa = free_slot;
			mem_wd = '{id: op_q.pkt_id, rem: op_q.timeout_ms,
				hnd: op_q.buffer_handle[HW-1:0]};
		end else if (vld_s1 && occ_s1 && is_elapse) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_s1 <= mem[rd_idx_q];
	end

	// Hold the request for the whole item.
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			op_q <= req.data;
		end
	end

	// Scan address and read data stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			vld_s1   <= 1'b0;
			occ_s1   <= 1'b0;
			idx_s1   <= '0;
			full_q   <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_SCAN);
			occ_s1 <= valid_q[rd_idx_q];
			idx_s1 <= rd_idx_q;
			if (req_xfer) begin
				rd_idx_q <= '0;
				full_q   <= &valid_q;
			end else if (state_q == ST_SCAN && rd_idx_q != LAST_SLOT) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
		end
	end

	// Accumulate over the scanned entries; slots arrive in ascending order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dup_q        <= 1'b0;
			del_hit_q    <= 1'b0;
			del_slot_q   <= '0;
			rel_handle_q <= '0;
			min_q        <= patt_pkg::TIME_ALL_ONES;
			exp_found_q  <= 1'b0;
			exp_slot_q   <= '0;
			exp_id_q     <= '0;
			exp_hnd_q    <= '0;
		end else if (req_xfer) begin
			dup_q       <= 1'b0;
			del_hit_q   <= 1'b0;
			min_q       <= patt_pkg::TIME_ALL_ONES;
			exp_found_q <= 1'b0;
		end else if (vld_s1) begin
			if (is_add && id_hit_s1) begin
				dup_q <= 1'b1;
			end
			if (is_delete && id_hit_s1) begin
				del_hit_q    <= 1'b1;
				del_slot_q   <= idx_s1;
				rel_handle_q <= rd_s1.hnd;
			end
			if (counted_s1) begin
				if (eff_rem_s1 < min_q) begin
					min_q <= eff_rem_s1;
				end
				if (eff_rem_s1 == '0 && !exp_found_q) begin
					exp_found_q <= 1'b1;
					exp_slot_q  <= idx_s1;
					exp_id_q    <= rd_s1.id;
					exp_hnd_q   <= rd_s1.hnd;
				end
			end
		end
	end

	// Occupancy: set on a committed add, drop on a delete hit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (finish_go) begin
			if (add_ok) begin
				valid_q[free_slot] <= 1'b1;
			end
			if (del_hit_q) begin
				valid_q[del_slot_q] <= 1'b0;
			end
		end
	end

	// Merge the added entry into the scan results.
	always_comb begin
		min_sel = min_q;
		if (add_ok && op_q.timeout_ms < min_q) begin
			min_sel = op_q.timeout_ms;
		end
		new_exp = add_ok && (op_q.timeout_ms == '0) &&
			(!exp_found_q || free_slot < exp_slot_q);
		fin_slot = exp_slot_q;
		fin_id   = exp_id_q;
		fin_hnd  = exp_hnd_q;
		if (new_exp) begin
			fin_slot = free_slot;
			fin_id   = op_q.pkt_id;
			fin_hnd  = op_q.buffer_handle[HW-1:0];
		end
		fin_slot_wide = {3'b000, fin_slot};
		fin_hnd_wide  = {8'h00, fin_hnd};
		rel_hnd_wide  = {8'h00, rel_handle_q};

		rsp_next = '0;
		rsp_next.accepted         = add_ok || del_hit_q || is_elapse;
		rsp_next.released_valid   = del_hit_q;
		rsp_next.min_remaining_ms = (min_sel == patt_pkg::TIME_ALL_ONES) ? '0 : min_sel;
		rsp_next.expired_found    = exp_found_q || new_exp;
		if (del_hit_q) begin
			rsp_next.released_handle = rel_hnd_wide[patt_pkg::HANDLE_PORT_BITS-1:0];
		end
		if (exp_found_q || new_exp) begin
			rsp_next.expired_slot   = fin_slot_wide[patt_pkg::SLOT_PORT_BITS-1:0];
			rsp_next.expired_pkt_id = fin_id;
			rsp_next.expired_handle = fin_hnd_wide[patt_pkg::HANDLE_PORT_BITS-1:0];
		end
	end

	// Sequencer and response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			rsp_data_q  <= '0;
		end else begin
			// Load a finished response; otherwise drop the held one once it
			// transfers.
			if (finish_go) begin
				rsp_valid_q <= 1'b1;
				rsp_data_q  <= rsp_next;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_xfer) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_idx_q == LAST_SLOT) begin
						state_q <= ST_TAIL;
					end
				end
				ST_TAIL: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (finish_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A response appears only out of the commit cycle.
	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("response raised outside commit");

	// A released buffer only comes with an accepted delete.
	a_release_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_data_q.released_valid |-> rsp_data_q.accepted)
		else $error("release without acceptance");

	// A nonzero least timeout needs an occupied slot; the occupancy cannot
	// change while the response waits.
	a_min_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_data_q.min_remaining_ms != '0 |-> valid_q != '0)
		else $error("least timeout reported for empty table");

	// Read data is worked only inside the scan.
	a_s1_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == ST_SCAN || state_q == ST_TAIL))
		else $error("scan data outside scan");

endmodule
